// ===== design/pc2_pkg.sv =====
// Shared constants, control struct and arctangent table for the 2D pose composer.
`timescale 1ns / 1ps
package pc2_pkg;

    localparam int COORD_WIDTH_DFLT     = 32;
    localparam int ANGLE_WIDTH_DFLT     = 16;
    localparam int ROTATION_STAGES_DFLT = 16;

    localparam int GUARD_BITS = 8;
    localparam int TURN_FRAC  = 32;   // angle accumulator units: 2^-32 turn
    localparam int GAIN_WIDTH = 32;
    localparam logic [GAIN_WIDTH-1:0] GAIN_INV = 32'd2608131496;
    localparam int POST_STAGES = 4;   // gain and saturation stages after the cells

    typedef struct packed {
        logic valid;
        logic bypass;                 // zero residual: quarter step only
    } t_ctl;

    function automatic logic [TURN_FRAC-1:0] atan_turn(input int idx);
        logic [TURN_FRAC-1:0] v;
        case (idx)
            0:       v = 32'd536870912;
            1:       v = 32'd316933406;
            2:       v = 32'd167458907;
            3:       v = 32'd85004756;
            4:       v = 32'd42667331;
            5:       v = 32'd21354465;
            6:       v = 32'd10679838;
            7:       v = 32'd5340245;
            8:       v = 32'd2670163;
            9:       v = 32'd1335087;
            10:      v = 32'd667544;
            11:      v = 32'd333772;
            12:      v = 32'd166886;
            13:      v = 32'd83443;
            14:      v = 32'd41722;
            15:      v = 32'd20861;
            16:      v = 32'd10430;
            17:      v = 32'd5215;
            18:      v = 32'd2608;
            19:      v = 32'd1304;
            20:      v = 32'd652;
            21:      v = 32'd326;
            22:      v = 32'd163;
            23:      v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/pc2_intf.sv =====
// Request and response channel interfaces of the 2D pose composer.
`timescale 1ns / 1ps
interface pc2_req_if #(
    parameter int COORD_WIDTH = pc2_pkg::COORD_WIDTH_DFLT,
    parameter int ANGLE_WIDTH = pc2_pkg::ANGLE_WIDTH_DFLT
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic        [ANGLE_WIDTH-1:0] first_angle;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic        [ANGLE_WIDTH-1:0] second_angle;

    modport source (
        output valid, first_x, first_y, first_angle, second_x, second_y, second_angle,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, first_angle, second_x, second_y, second_angle,
        output ready
    );
endinterface

interface pc2_rsp_if #(
    parameter int COORD_WIDTH = pc2_pkg::COORD_WIDTH_DFLT,
    parameter int ANGLE_WIDTH = pc2_pkg::ANGLE_WIDTH_DFLT
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic        [ANGLE_WIDTH-1:0] out_angle;
    logic                          overflow;

    modport source (output valid, out_x, out_y, out_angle, overflow, input ready);
    modport sink   (input  valid, out_x, out_y, out_angle, overflow, output ready);
endinterface

// ===== design/pc2_quad.sv =====
// Entry stage: quarter-turn rotation, residual angle and heading sum.
`timescale 1ns / 1ps
module pc2_quad #(
    parameter int CW = 32,
    parameter int AW = 16,
    parameter int XW = 43,
    parameter int ZW = 33,
    parameter int SW = 80
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [CW-1:0] i_first_x,
    input  logic signed [CW-1:0] i_first_y,
    input  logic        [AW-1:0] i_first_angle,
    input  logic signed [CW-1:0] i_second_x,
    input  logic signed [CW-1:0] i_second_y,
    input  logic        [AW-1:0] i_second_angle,
    output pc2_pkg::t_ctl        o_ctl,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic signed [ZW-1:0] o_z,
    output logic        [SW-1:0] o_side
);
    import pc2_pkg::*;

    localparam int EW = CW + 1;
    localparam logic [AW-2:0] EIGHTH = (AW-1)'(1) << (AW - 3);

    logic signed [EW-1:0] sx_e, sy_e, qx, qy;
    logic        [AW-1:0] biased;
    logic        [1:0]    quad;
    logic        [AW-3:0] low;
    logic signed [AW-2:0] resid;

    t_ctl                 r_ctl, n_ctl;
    logic signed [XW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic        [SW-1:0] r_side;

    always_comb begin
        sx_e   = EW'(i_second_x);
        sy_e   = EW'(i_second_y);
        biased = i_first_angle + AW'(EIGHTH);
        quad   = biased[AW-1 -: 2];
        low    = biased[AW-3:0];
        resid  = $signed({1'b0, low}) - $signed(EIGHTH);
        case (quad)
            2'd1: begin
                qx = -sy_e;
                qy = sx_e;
            end
            2'd2: begin
                qx = -sx_e;
                qy = -sy_e;
            end
            2'd3: begin
                qx = sy_e;
                qy = -sx_e;
            end
            default: begin
                qx = sx_e;
                qy = sy_e;
            end
        endcase
        n_ctl.valid  = i_valid;
        n_ctl.bypass = ({1'b0, low} == EIGHTH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
        if (i_en) begin
            r_x    <= XW'(qx) <<< GUARD_BITS;
            r_y    <= XW'(qy) <<< GUARD_BITS;
            r_z    <= ZW'(resid) <<< (TURN_FRAC - AW);
            r_side <= {i_first_x, i_first_y, AW'(i_first_angle + i_second_angle)};
        end
    end

    assign o_ctl  = r_ctl;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_side = r_side;

endmodule

// ===== design/pc2_cell.sv =====
// One CORDIC micro-rotation cell of the rotation chain.
`timescale 1ns / 1ps
module pc2_cell #(
    parameter int XW    = 43,
    parameter int ZW    = 33,
    parameter int SW    = 80,
    parameter int STAGE = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  pc2_pkg::t_ctl        i_ctl,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    input  logic        [SW-1:0] i_side,
    output pc2_pkg::t_ctl        o_ctl,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic signed [ZW-1:0] o_z,
    output logic        [SW-1:0] o_side
);
    import pc2_pkg::*;

    localparam logic [ZW-1:0] ATAN = ZW'(atan_turn(STAGE));

    logic signed [XW-1:0] dx, dy, n_x, n_y;
    logic signed [ZW-1:0] n_z;

    t_ctl                 r_ctl;
    logic signed [XW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic        [SW-1:0] r_side;

    always_comb begin
        dx = i_y >>> STAGE;
        dy = i_x >>> STAGE;
        if (i_ctl.bypass) begin
            n_x = i_x;
            n_y = i_y;
            n_z = i_z;
        end else if (!i_z[ZW-1]) begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - $signed(ATAN);
        end else begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + $signed(ATAN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_side = r_side;

endmodule

// ===== design/pc2_post.sv =====
// Gain correction, rounding, translation add and saturation for one coordinate.
`timescale 1ns / 1ps
module pc2_post #(
    parameter int CW = 32,
    parameter int XW = 43
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  pc2_pkg::t_ctl        i_ctl,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [CW-1:0] i_f,
    output pc2_pkg::t_ctl        o_ctl,
    output logic signed [CW-1:0] o_val,
    output logic                 o_ovf
);
    import pc2_pkg::*;

    localparam int LO  = (XW + 1) / 2;
    localparam int HI  = XW - LO;
    localparam int FW  = XW + GAIN_WIDTH + 1;
    localparam int RW  = FW - GAIN_WIDTH - GUARD_BITS;
    localparam int BW  = XW - GUARD_BITS;
    localparam int SMW = RW + 2;
    localparam logic [FW-1:0] RND = FW'(1) << (GAIN_WIDTH - 1 + GUARD_BITS);
    localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

    // stage 1: sign and magnitude
    t_ctl                 r_s1_ctl;
    logic                 r_s1_neg;
    logic        [XW-1:0] r_s1_mag;
    logic signed [BW-1:0] r_s1_bx;
    logic signed [CW-1:0] r_s1_f;
    // stage 2: partial products
    t_ctl                         r_s2_ctl;
    logic                         r_s2_neg;
    logic [LO+GAIN_WIDTH-1:0]     r_s2_pp_lo;
    logic [HI+GAIN_WIDTH-1:0]     r_s2_pp_hi;
    logic signed [BW-1:0]         r_s2_bx;
    logic signed [CW-1:0]         r_s2_f;
    // stage 3: rounded magnitude
    t_ctl                 r_s3_ctl;
    logic                 r_s3_neg;
    logic        [RW-1:0] r_s3_r;
    logic signed [BW-1:0] r_s3_bx;
    logic signed [CW-1:0] r_s3_f;
    // stage 4: output
    t_ctl                 r_s4_ctl;
    logic signed [CW-1:0] r_s4_val;
    logic                 r_s4_ovf;

    logic        [FW-1:0]  full;
    logic signed [SMW-1:0] sum;
    logic                  sat;
    logic signed [CW-1:0]  n_val;

    always_comb begin
        full = (FW'(r_s2_pp_hi) << LO) + FW'(r_s2_pp_lo) + RND;
        if (r_s3_ctl.bypass) begin
            sum = $signed(SMW'(r_s3_f)) + $signed(SMW'(r_s3_bx));
        end else if (r_s3_neg) begin
            sum = $signed(SMW'(r_s3_f)) - $signed(SMW'({1'b0, r_s3_r}));
        end else begin
            sum = $signed(SMW'(r_s3_f)) + $signed(SMW'({1'b0, r_s3_r}));
        end
        sat = !((&sum[SMW-1:CW-1]) || !(|sum[SMW-1:CW-1]));
        if (!sat) begin
            n_val = sum[CW-1:0];
        end else if (sum[SMW-1]) begin
            n_val = MINV;
        end else begin
            n_val = MAXV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
            r_s3_ctl <= '0;
            r_s4_ctl <= '0;
        end else if (i_en) begin
            r_s1_ctl <= i_ctl;
            r_s2_ctl <= r_s1_ctl;
            r_s3_ctl <= r_s2_ctl;
            r_s4_ctl <= r_s3_ctl;
        end
        if (i_en) begin
            r_s1_neg   <= i_x[XW-1];
            r_s1_mag   <= i_x[XW-1] ? XW'(-i_x) : XW'(i_x);
            r_s1_bx    <= BW'(i_x >>> GUARD_BITS);
            r_s1_f     <= i_f;
            r_s2_neg   <= r_s1_neg;
            r_s2_pp_lo <= (LO+GAIN_WIDTH)'(r_s1_mag[LO-1:0]) * (LO+GAIN_WIDTH)'(GAIN_INV);
            r_s2_pp_hi <= (HI+GAIN_WIDTH)'(r_s1_mag[XW-1:LO]) * (HI+GAIN_WIDTH)'(GAIN_INV);
            r_s2_bx    <= r_s1_bx;
            r_s2_f     <= r_s1_f;
            r_s3_neg   <= r_s2_neg;
            r_s3_r     <= full[FW-1 -: RW];
            r_s3_bx    <= r_s2_bx;
            r_s3_f     <= r_s2_f;
            r_s4_val   <= n_val;
            r_s4_ovf   <= sat;
        end
    end

    assign o_ctl = r_s4_ctl;
    assign o_val = r_s4_val;
    assign o_ovf = r_s4_ovf;

endmodule

// ===== design/pose_compose_2d.sv =====
// Top level of the 2D pose composer: entry stage, CORDIC cell chain, output stages.
//
// Use: i_req carries a request of two poses (first x/y/angle, second x/y/angle);
// o_rsp returns the composed pose: the second translation rotated by the first
// heading plus the first translation, saturated to COORD_WIDTH bits, the heading
// sum modulo one turn, and an overflow flag set when x or y was clamped. To map
// a point, send it as the second pose and ignore out_angle.
// Stages from request to response: one entry stage, one cell per
// micro-rotation, and four gain/rounding/add stages.
// Throughput: one request per cycle while o_rsp is not stalled; the whole cell
// chain advances together, so requests in flight move one stage per clock.
// Stall: when o_rsp holds a response that is not taken, the chain freezes and
// i_req.ready drops in the same cycle; nothing is lost or repeated.
// Reset: synchronous, active low; all stage valid bits clear, no response is
// pending, and the block accepts requests in the first cycle after reset.
`timescale 1ns / 1ps
module pose_compose_2d #(
    parameter int COORD_WIDTH     = pc2_pkg::COORD_WIDTH_DFLT,
    parameter int ANGLE_WIDTH     = pc2_pkg::ANGLE_WIDTH_DFLT,
    parameter int ROTATION_STAGES = pc2_pkg::ROTATION_STAGES_DFLT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pc2_req_if.sink   i_req,
    pc2_rsp_if.source o_rsp
);
    import pc2_pkg::*;

    localparam int XW = COORD_WIDTH + GUARD_BITS + 3;
    localparam int ZW = TURN_FRAC + 1;
    localparam int SW = 2 * COORD_WIDTH + ANGLE_WIDTH;
    localparam int NS = ROTATION_STAGES;

    t_ctl                 w_ctl  [0:NS];
    logic signed [XW-1:0] w_x    [0:NS];
    logic signed [XW-1:0] w_y    [0:NS];
    logic signed [ZW-1:0] w_z    [0:NS];
    logic        [SW-1:0] w_side [0:NS];

    t_ctl                          w_out_ctl;
    logic signed [COORD_WIDTH-1:0] w_fx, w_fy, w_ox, w_oy;
    logic                          w_ovf_x, w_ovf_y;
    logic                          en;

    logic [ANGLE_WIDTH-1:0] r_ang [0:POST_STAGES-1];

    assign en          = !w_out_ctl.valid || o_rsp.ready;
    assign i_req.ready = en;

    pc2_quad #(
        .CW (COORD_WIDTH),
        .AW (ANGLE_WIDTH),
        .XW (XW),
        .ZW (ZW),
        .SW (SW)
    ) u_quad (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (i_req.valid),
        .i_first_x      (i_req.first_x),
        .i_first_y      (i_req.first_y),
        .i_first_angle  (i_req.first_angle),
        .i_second_x     (i_req.second_x),
        .i_second_y     (i_req.second_y),
        .i_second_angle (i_req.second_angle),
        .o_ctl          (w_ctl[0]),
        .o_x            (w_x[0]),
        .o_y            (w_y[0]),
        .o_z            (w_z[0]),
        .o_side         (w_side[0])
    );

    for (genvar g = 0; g < NS; g++) begin : g_cell
        pc2_cell #(
            .XW    (XW),
            .ZW    (ZW),
            .SW    (SW),
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (w_ctl[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .i_side  (w_side[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    assign w_fx = w_side[NS][SW-1 -: COORD_WIDTH];
    assign w_fy = w_side[NS][ANGLE_WIDTH +: COORD_WIDTH];

    pc2_post #(
        .CW (COORD_WIDTH),
        .XW (XW)
    ) u_post_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (w_ctl[NS]),
        .i_x     (w_x[NS]),
        .i_f     (w_fx),
        .o_ctl   (w_out_ctl),
        .o_val   (w_ox),
        .o_ovf   (w_ovf_x)
    );

    pc2_post #(
        .CW (COORD_WIDTH),
        .XW (XW)
    ) u_post_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (w_ctl[NS]),
        .i_x     (w_y[NS]),
        .i_f     (w_fy),
        .o_ctl   (),
        .o_val   (w_oy),
        .o_ovf   (w_ovf_y)
    );

    // heading sum rides alongside the output stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ang[0] <= w_side[NS][ANGLE_WIDTH-1:0];
            for (int k = 1; k < POST_STAGES; k++) begin
                r_ang[k] <= r_ang[k-1];
            end
        end
    end

    assign o_rsp.valid     = w_out_ctl.valid;
    assign o_rsp.out_x     = w_ox;
    assign o_rsp.out_y     = w_oy;
    assign o_rsp.out_angle = r_ang[POST_STAGES-1];
    assign o_rsp.overflow  = w_ovf_x | w_ovf_y;

endmodule

// ===== tb/sv/pose_compose_2d_checker.sv =====
// Response checker for the 2D pose composer: predicts each composed pose and compares.
`timescale 1ns / 1ps
module pose_compose_2d_checker #(
    parameter int COORD_WIDTH     = pc2_pkg::COORD_WIDTH_DFLT,
    parameter int ANGLE_WIDTH     = pc2_pkg::ANGLE_WIDTH_DFLT,
    parameter int ROTATION_STAGES = pc2_pkg::ROTATION_STAGES_DFLT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pc2_req_if   i_req,
    pc2_rsp_if   i_rsp,
    output int   o_error_count,
    output int   o_outstanding
);
    import pc2_pkg::*;

    localparam int ARCTAN_STEPS = 24;
    localparam longint ARCTAN_TURNS [ARCTAN_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic        [ANGLE_WIDTH-1:0] angle;
        logic                          overflow;
    } t_composed_pose;

    t_composed_pose expected_poses[$];
    int             response_index;

    initial begin
        o_error_count  = 0;
        o_outstanding  = 0;
        response_index = 0;
    end

    // gain correction, rounded half away from zero
    function automatic longint scale_gain(input longint v);
        logic [127:0] mag;
        logic [127:0] scaled;
        mag    = 128'((v < 0) ? -v : v);
        scaled = (mag * GAIN_INV + (128'd1 << (TURN_FRAC + GUARD_BITS - 1)))
                 >> (TURN_FRAC + GUARD_BITS);
        return (v < 0) ? -longint'(scaled[63:0]) : longint'(scaled[63:0]);
    endfunction

    function automatic longint clamp_coord(input longint v);
        longint top;
        top = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
        if (v > top)
            return top;
        if (v < -top - 1)
            return -top - 1;
        return v;
    endfunction

    function automatic t_composed_pose compose_pose(
        input logic signed [COORD_WIDTH-1:0] fx,
        input logic signed [COORD_WIDTH-1:0] fy,
        input logic        [ANGLE_WIDTH-1:0] fa,
        input logic signed [COORD_WIDTH-1:0] sx,
        input logic signed [COORD_WIDTH-1:0] sy,
        input logic        [ANGLE_WIDTH-1:0] sa
    );
        longint             x, y, z, dx, dy, px, py, sum_x, sum_y, lim_x, lim_y, residual;
        logic [ANGLE_WIDTH:0] biased;
        t_composed_pose     res;
        biased   = (ANGLE_WIDTH+1)'(fa) + (ANGLE_WIDTH+1)'(1 << (ANGLE_WIDTH - 3));
        residual = longint'(biased[ANGLE_WIDTH-3:0]);
        residual = residual - (longint'(1) <<< (ANGLE_WIDTH - 3));
        case (biased[ANGLE_WIDTH-1 -: 2])
            2'd1: begin
                x = -longint'(sy);
                y = longint'(sx);
            end
            2'd2: begin
                x = -longint'(sx);
                y = -longint'(sy);
            end
            2'd3: begin
                x = longint'(sy);
                y = -longint'(sx);
            end
            default: begin
                x = longint'(sx);
                y = longint'(sy);
            end
        endcase
        if (residual == 0) begin
            px = x;
            py = y;
        end else begin
            z = residual <<< (TURN_FRAC - ANGLE_WIDTH);
            x = x <<< GUARD_BITS;
            y = y <<< GUARD_BITS;
            for (int i = 0; i < ROTATION_STAGES && i < ARCTAN_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ARCTAN_TURNS[i];
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ARCTAN_TURNS[i];
                end
            end
            px = scale_gain(x);
            py = scale_gain(y);
        end
        sum_x        = longint'(fx) + px;
        sum_y        = longint'(fy) + py;
        lim_x        = clamp_coord(sum_x);
        lim_y        = clamp_coord(sum_y);
        res.x        = COORD_WIDTH'(lim_x);
        res.y        = COORD_WIDTH'(lim_y);
        res.angle    = fa + sa;
        res.overflow = (lim_x != sum_x) || (lim_y != sum_y);
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        o_error_count++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_composed_pose want;
        if (!i_rst_n) begin
            expected_poses.delete();
        end else begin
            if (i_req.valid && i_req.ready)
                expected_poses.push_back(compose_pose(i_req.first_x, i_req.first_y,
                    i_req.first_angle, i_req.second_x, i_req.second_y, i_req.second_angle));
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_poses.size() == 0) begin
                    report_mismatch($sformatf("response %0d with no request pending",
                        response_index));
                end else begin
                    want = expected_poses.pop_front();
                    if (i_rsp.out_x !== want.x)
                        report_mismatch($sformatf("response %0d out_x got %0d expected %0d",
                            response_index, i_rsp.out_x, want.x));
                    if (i_rsp.out_y !== want.y)
                        report_mismatch($sformatf("response %0d out_y got %0d expected %0d",
                            response_index, i_rsp.out_y, want.y));
                    if (i_rsp.out_angle !== want.angle)
                        report_mismatch($sformatf("response %0d out_angle got %0d expected %0d",
                            response_index, i_rsp.out_angle, want.angle));
                    if (i_rsp.overflow !== want.overflow)
                        report_mismatch($sformatf("response %0d overflow got %b expected %b",
                            response_index, i_rsp.overflow, want.overflow));
                end
                response_index++;
            end
        end
        o_outstanding = expected_poses.size();
    end

endmodule

// ===== tb/sv/pose_compose_2d_tb.sv =====
// Testbench top for the 2D pose composer: clock, reset, request stimulus, verdict.
`timescale 1ns / 1ps
module pose_compose_2d_tb;
    import pc2_pkg::*;

    localparam int CW              = COORD_WIDTH_DFLT;
    localparam int AW              = ANGLE_WIDTH_DFLT;
    localparam int LATENCY         = ROTATION_STAGES_DFLT + POST_STAGES + 1;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_REQUESTS = 900;
    localparam int LONG_HOLD       = 300;

    localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW-1:0] ONE       = 1 << 16;
    localparam logic [AW-1:0] QUARTER   = AW'(1) << (AW - 2);
    localparam logic [AW-1:0] EIGHTH    = AW'(1) << (AW - 3);

    logic i_clk;
    logic i_rst_n;
    int   cycle_count = 0;
    int   error_count;
    int   outstanding;
    int   hold_requests = 0;

    pc2_req_if #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) req_ch ();
    pc2_rsp_if #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) rsp_ch ();

    pose_compose_2d dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    pose_compose_2d_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .o_error_count (error_count),
        .o_outstanding (outstanding)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // response side: random stall patterns, plus a long hold when asked
    initial begin : response_drain
        int mode;
        int span;
        int holds_done;
        holds_done   = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
            for (int k = 0; k < span; k++) begin
                @(negedge i_clk);
                if (hold_requests != holds_done) begin
                    rsp_ch.ready <= 1'b0;
                    for (int h = 0; h < LONG_HOLD; h++)
                        @(negedge i_clk);
                    holds_done++;
                end else begin
                    case (mode)
                        0:       rsp_ch.ready <= 1'b1;
                        1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                        2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                        default: rsp_ch.ready <= (k % 3 != 2);
                    endcase
                end
            end
        end
    end

    function automatic logic [CW-1:0] pick_coord();
        case ($urandom_range(0, 9))
            5, 6:    return $urandom_range(0, 2 << 20) - (1 << 20);
            7:       return COORD_MAX - $urandom_range(0, 255);
            8:       return COORD_MIN + $urandom_range(0, 255);
            9:       return $urandom_range(0, 15) - 8;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [AW-1:0] pick_angle();
        case ($urandom_range(0, 9))
            5:       return AW'(QUARTER * $urandom_range(0, 3));
            6:       return AW'(QUARTER * $urandom_range(0, 3) + $urandom_range(0, 6) - 3);
            7:       return AW'(EIGHTH + QUARTER * $urandom_range(0, 3)
                                + $urandom_range(0, 4) - 2);
            8:       return '0;
            default: return AW'($urandom_range(0, (1 << AW) - 1));
        endcase
    endfunction

    // holds the request until it is taken, returns at the following falling edge
    task automatic send_pose(input logic [CW-1:0] fx, input logic [CW-1:0] fy,
                             input logic [AW-1:0] fa, input logic [CW-1:0] sx,
                             input logic [CW-1:0] sy, input logic [AW-1:0] sa);
        req_ch.valid        <= 1'b1;
        req_ch.first_x      <= fx;
        req_ch.first_y      <= fy;
        req_ch.first_angle  <= fa;
        req_ch.second_x     <= sx;
        req_ch.second_y     <= sy;
        req_ch.second_angle <= sa;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0)
            @(negedge i_clk);
    endtask

    initial begin : request_source
        int  sent;
        int  burst;
        int  gap;
        bit  hold_done;
        bit  pause_done;
        sent                = 0;
        hold_done           = 1'b0;
        pause_done          = 1'b0;
        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.first_x      = '0;
        req_ch.first_y      = '0;
        req_ch.first_angle  = '0;
        req_ch.second_x     = '0;
        req_ch.second_y     = '0;
        req_ch.second_angle = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_pose('0, '0, '0, '0, '0, '0);
        send_pose('0, '0, '0, 1, -1, '0);
        send_pose(ONE, -ONE, QUARTER, ONE, 2 * ONE, AW'(3));
        send_pose(-ONE, ONE, AW'(2 * QUARTER), ONE, 2 * ONE, QUARTER);
        send_pose(ONE, ONE, AW'(3 * QUARTER), ONE, 2 * ONE, AW'(2 * QUARTER));
        send_pose('0, '0, AW'(2 * QUARTER), COORD_MIN, COORD_MIN, '0);
        send_pose(COORD_MAX, COORD_MIN, '0, COORD_MAX, COORD_MIN, '0);
        send_pose(COORD_MIN, COORD_MAX, '0, COORD_MIN, COORD_MAX, '0);
        send_pose('0, '0, AW'(EIGHTH - 1), COORD_MAX, COORD_MAX, '0);
        send_pose('0, '0, EIGHTH, COORD_MIN, COORD_MAX, '0);
        send_pose(COORD_MAX, '0, AW'(3 * EIGHTH), COORD_MAX, COORD_MIN, '0);
        send_pose('0, COORD_MIN, AW'(1), COORD_MAX, COORD_MAX, '0);
        send_pose('0, '0, '1, COORD_MIN, COORD_MIN, AW'(1));
        send_pose(ONE, ONE, 16'd40000, 3 * ONE, -5 * ONE, 16'd40000);
        send_pose('0, '0, '0, 7 * ONE, ONE, '1);
        send_pose('1, '1, '1, '1, '1, '1);
        send_pose(10 * ONE, -4 * ONE, 16'd12345, 5 * ONE, -3 * ONE, '0);
        send_pose(COORD_MAX, COORD_MAX, AW'(5 * EIGHTH + 17), COORD_MAX, COORD_MAX, '0);
        send_pose(COORD_MIN, COORD_MIN, AW'(7 * EIGHTH - 1), COORD_MIN, COORD_MIN, '0);

        while (sent < RANDOM_REQUESTS) begin
            burst = $urandom_range(1, 40);
            if (!hold_done && sent >= 300) begin
                hold_requests <= hold_requests + 1;
                hold_done = 1'b1;
                burst     = 80;
            end
            if (!pause_done && sent >= 600) begin
                wait_drained();
                pause_done = 1'b1;
            end
            for (int b = 0; b < burst && sent < RANDOM_REQUESTS; b++) begin
                send_pose(pick_coord(), pick_coord(), pick_angle(),
                          pick_coord(), pick_coord(), pick_angle());
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap != 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end

        wait_drained();
        repeat (2 * LATENCY) @(negedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/pc2_pkg.sv
design/pc2_intf.sv
design/pc2_quad.sv
design/pc2_cell.sv
design/pc2_post.sv
design/pose_compose_2d.sv
tb/sv/pose_compose_2d_checker.sv
tb/sv/pose_compose_2d_tb.sv
